/* sv/hsl_pkg.sv */
// hsl_pkg: shared types and constants of the heading slew limiter.
// Angle format, CORDIC arctangent table, register indexes.
// No dependencies.
package hsl_pkg;

	localparam int ANGLE_FRAC_BITS = 13;
	localparam int ANGLE_W         = 16;
	localparam int WIDE_W          = 20;
	localparam int MAX_STEP_W      = 13;
	localparam int MAX_RATE_W      = 15;
	localparam int CFG_DATA_W      = 15;
	localparam int CFG_INDEX_W     = 1;

	localparam longint unsigned PI_SCALED32 = 64'd13493037705;
	localparam longint PI_Q = longint'((PI_SCALED32 + (64'd1 << (31 - ANGLE_FRAC_BITS)))
		>> (32 - ANGLE_FRAC_BITS));

	localparam int CORDIC_ITERS = 24;
	localparam int ITER_W       = $clog2(CORDIC_ITERS);
	localparam int CORD_X_W     = 33;
	localparam int CORD_Z_W     = 34;
	localparam int VEL_SHIFT    = 14;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;

	localparam logic [29:0] ATAN_Q30 [CORDIC_ITERS] = '{
		30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
		30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
		30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535,
		30'd32767, 30'd16383, 30'd8191, 30'd4095, 30'd2047,
		30'd1023, 30'd511, 30'd255, 30'd127
	};

	localparam logic [CFG_INDEX_W-1:0] REG_MAX_STEP = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_RATE = 1'd1;

	localparam logic [MAX_STEP_W-1:0] RESET_MAX_STEP = 13'd257;
	localparam logic [MAX_RATE_W-1:0] RESET_MAX_RATE = 15'd25736;

	typedef logic signed [ANGLE_W-1:0] angle_t;
	typedef logic signed [WIDE_W-1:0]  wide_t;
	typedef logic signed [15:0]        vel_t;

endpackage

/* sv/heading_slew_limiter.sv */
// heading_slew_limiter: velocity to slew-limited, smoothed heading and rate.
// Steps from input transaction to result valid: 24 CORDIC iterations in
// hsl_cordic, rounding, target select, limit, average.
// A new transaction is taken only after the previous result is registered at the output; in_stall is high until then.
// Reset: asynchronous, clears state and history, loads register defaults.
// Depends on hsl_pkg and hsl_cordic.
module heading_slew_limiter (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  hsl_pkg::vel_t                       vel_x,
	input  hsl_pkg::vel_t                       vel_y,
	input  hsl_pkg::vel_t                       vel_z,
	output logic                                out_valid,
	input  logic                                out_stall,
	output hsl_pkg::angle_t                     heading,
	output hsl_pkg::angle_t                     heading_rate,
	input  logic                                cfg_wr_en,
	input  logic [hsl_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [hsl_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import hsl_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ATAN,
		S_LIMIT,
		S_AVG
	} state_t;

	localparam int PROD_W = 28;
	localparam wide_t PI_W  = WIDE_W'(PI_Q);
	localparam wide_t PI2_W = WIDE_W'(2 * PI_Q);

	state_t                  st_q;
	logic [MAX_STEP_W-1:0]   max_step_q;
	logic [MAX_RATE_W-1:0]   max_rate_q;
	angle_t                  prev_heading_q, prev_rate_q;
	logic                    zero_xy_q, zero_all_q;
	wide_t                   tgt_q, yaw_q;
	angle_t                  rate_q;

	logic                    in_accept, atan_done;
	angle_t                  atan_angle;
	wide_t                   l_w, m_w, r_w, d, yaw_c, dec_c, inc_c, diff;
	angle_t                  rate_c, heading_c, heading_rate_c;
	logic signed [PROD_W-1:0] prod, r_p;
	logic signed [WIDE_W:0]  sum_h;
	logic signed [ANGLE_W:0] sum_r;
	logic                    advance;

	assign in_stall  = (st_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign advance   = (st_q == S_AVG) && (!out_valid || !out_stall);

	hsl_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_accept),
		.vel_x  (vel_x),
		.vel_y  (vel_y),
		.done   (atan_done),
		.angle  (atan_angle)
	);

	assign l_w = WIDE_W'(prev_heading_q);
	assign m_w = {{(WIDE_W-MAX_STEP_W){1'b0}}, max_step_q};
	assign r_w = {{(WIDE_W-MAX_RATE_W){1'b0}}, max_rate_q};
	assign r_p = {{(PROD_W-MAX_RATE_W){1'b0}}, max_rate_q};
	assign d   = tgt_q - l_w;
	assign prod = PROD_W'(d) * PROD_W'(100);

	always_comb begin
		dec_c = l_w - m_w;
		if (dec_c < -PI_W) begin
			dec_c = dec_c + PI2_W;
		end
		inc_c = l_w + m_w;
		if (inc_c > PI_W) begin
			inc_c = inc_c - PI2_W;
		end
		if (d > PI_W) begin
			yaw_c  = (d - PI2_W < -m_w) ? dec_c : tgt_q;
			rate_c = ANGLE_W'(-r_w);
		end else if (d < -PI_W) begin
			yaw_c  = (d + PI2_W > m_w) ? inc_c : tgt_q;
			rate_c = ANGLE_W'(r_w);
		end else if (d < -m_w) begin
			yaw_c  = dec_c;
			rate_c = ANGLE_W'(-r_w);
		end else if (d > m_w) begin
			yaw_c  = inc_c;
			rate_c = ANGLE_W'(r_w);
		end else begin
			yaw_c = tgt_q;
			if (prod > r_p) begin
				rate_c = ANGLE_W'(r_w);
			end else if (prod < -r_p) begin
				rate_c = ANGLE_W'(-r_w);
			end else begin
				rate_c = ANGLE_W'(prod);
			end
		end
	end

	assign diff  = yaw_q - l_w;
	assign sum_h = (WIDE_W+1)'(yaw_q) + (WIDE_W+1)'(prev_heading_q);
	assign sum_r = (ANGLE_W+1)'(rate_q) + (ANGLE_W+1)'(prev_rate_q);
	assign heading_c = ((diff <= m_w) && (diff >= -m_w)) ? ANGLE_W'(sum_h >>> 1)
		: ANGLE_W'(yaw_q);
	assign heading_rate_c = ANGLE_W'(sum_r >>> 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q           <= S_IDLE;
			max_step_q     <= RESET_MAX_STEP;
			max_rate_q     <= RESET_MAX_RATE;
			prev_heading_q <= '0;
			prev_rate_q    <= '0;
			zero_xy_q      <= 1'b0;
			zero_all_q     <= 1'b0;
			tgt_q          <= '0;
			yaw_q          <= '0;
			rate_q         <= '0;
			out_valid      <= 1'b0;
			heading        <= '0;
			heading_rate   <= '0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_MAX_STEP: max_step_q <= cfg_data[MAX_STEP_W-1:0];
					REG_MAX_RATE: max_rate_q <= cfg_data[MAX_RATE_W-1:0];
					default: ;
				endcase
			end
			if (advance) begin
				out_valid <= 1'b1;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			case (st_q)
				S_IDLE: begin
					if (in_accept) begin
						zero_xy_q  <= (vel_x == '0) && (vel_y == '0);
						zero_all_q <= (vel_x == '0) && (vel_y == '0) && (vel_z == '0);
						st_q       <= S_ATAN;
					end
				end
				S_ATAN: begin
					if (atan_done) begin
						if (zero_all_q) begin
							tgt_q <= l_w;
						end else if (zero_xy_q) begin
							tgt_q <= '0;
						end else begin
							tgt_q <= WIDE_W'(atan_angle);
						end
						st_q <= S_LIMIT;
					end
				end
				S_LIMIT: begin
					yaw_q  <= yaw_c;
					rate_q <= rate_c;
					st_q   <= S_AVG;
				end
				S_AVG: begin
					if (advance) begin
						heading        <= heading_c;
						heading_rate   <= heading_rate_c;
						prev_heading_q <= heading_c;
						prev_rate_q    <= heading_rate_c;
						st_q           <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	a_done_waits: assert property (@(posedge clk) disable iff (!arst_n)
		atan_done |-> (st_q == S_ATAN))
		else $error("arctangent result arrived outside its wait state");

	a_history: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (prev_heading_q == heading) && (prev_rate_q == heading_rate))
		else $error("history differs from delivered result");

	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(st_q == S_AVG))
		else $error("result raised outside the averaging step");

endmodule

/* sv/hsl_cordic.sv */
// hsl_cordic: iterative vectoring CORDIC giving atan2(vel_y, vel_x).
// One shift-add iteration per cycle, rounded and clamped to +-pi in Q3.13.
// Depends on hsl_pkg.
module hsl_cordic (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  hsl_pkg::vel_t   vel_x,
	input  hsl_pkg::vel_t   vel_y,
	output logic            done,
	output hsl_pkg::angle_t angle
);
	import hsl_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ITER,
		S_ROUND
	} state_t;

	localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(CORDIC_ITERS - 1);
	localparam logic signed [CORD_Z_W-1:0] HALF_PI_Z = CORD_Z_W'(HALF_PI_Q30);
	localparam logic signed [CORD_Z_W-1:0] PI_Z      = CORD_Z_W'(PI_Q);
	localparam logic signed [CORD_Z_W-1:0] ROUND_Z   =
		CORD_Z_W'(64'sd1 << (29 - ANGLE_FRAC_BITS));

	state_t                      st_q;
	logic [ITER_W-1:0]           iter_q;
	logic signed [CORD_X_W-1:0]  x_q, y_q;
	logic signed [CORD_Z_W-1:0]  z_q;

	logic signed [CORD_X_W-1:0]  x0, y0, dx, dy;
	logic signed [CORD_Z_W-1:0]  atan_z, z_rnd;
	logic                        y_pos;

	assign x0     = CORD_X_W'(vel_x) <<< VEL_SHIFT;
	assign y0     = CORD_X_W'(vel_y) <<< VEL_SHIFT;
	assign dx     = y_q >>> iter_q;
	assign dy     = x_q >>> iter_q;
	assign y_pos  = !y_q[CORD_X_W-1] && (|y_q);
	assign atan_z = signed'({{(CORD_Z_W-30){1'b0}}, ATAN_Q30[iter_q]});
	assign z_rnd  = (z_q + ROUND_Z) >>> (30 - ANGLE_FRAC_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= S_IDLE;
			iter_q <= '0;
			x_q    <= '0;
			y_q    <= '0;
			z_q    <= '0;
			done   <= 1'b0;
			angle  <= '0;
		end else begin
			done <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (start) begin
						iter_q <= '0;
						st_q   <= S_ITER;
						if (!x0[CORD_X_W-1]) begin
							x_q <= x0;
							y_q <= y0;
							z_q <= '0;
						end else if (!y0[CORD_X_W-1]) begin
							x_q <= y0;
							y_q <= -x0;
							z_q <= HALF_PI_Z;
						end else begin
							x_q <= -y0;
							y_q <= x0;
							z_q <= -HALF_PI_Z;
						end
					end
				end
				S_ITER: begin
					if (y_pos) begin
						x_q <= x_q + dx;
						y_q <= y_q - dy;
						z_q <= z_q + atan_z;
					end else begin
						x_q <= x_q - dx;
						y_q <= y_q + dy;
						z_q <= z_q - atan_z;
					end
					if (iter_q == LAST_ITER) begin
						st_q <= S_ROUND;
					end else begin
						iter_q <= iter_q + 1'b1;
					end
				end
				S_ROUND: begin
					if (z_rnd > PI_Z) begin
						angle <= ANGLE_W'(PI_Z);
					end else if (z_rnd < -PI_Z) begin
						angle <= ANGLE_W'(-PI_Z);
					end else begin
						angle <= ANGLE_W'(z_rnd);
					end
					done <= 1'b1;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	a_iter_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_ITER) |-> (iter_q <= LAST_ITER))
		else $error("iteration count beyond table");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> (st_q == S_IDLE))
		else $error("start while busy");

endmodule
